// ----- sv/e2cal_pkg.sv -----
// Package for the epoch-seconds to calendar converter.
// Constants, the split-time record passed between front and back, and the month table.
// No dependencies.
`default_nettype none

package e2cal_pkg;

	localparam int SecsPerDay  = 86400;
	localparam int SecsPerHour = 3600;
	localparam int SecsPerMin  = 60;
	localparam int BaseYear    = 2000;
	localparam int MaxYear     = 2136;
	localparam int YearLenLeap = 366;
	localparam int YearLenStd  = 365;
	localparam int CentYears   = 100;
	localparam int QuadCent    = 400;
	localparam int MonthsPerYr = 12;
	localparam int MonthFeb    = 2;

	// constant divides: strip the power of two, then multiply by a rounded-up reciprocal
	localparam int DayShift    = 7;         // 86400 = 675 << 7
	localparam int DayOdd      = 675;
	localparam int DayRecip    = 50903317;  // ceil(2^35 / 675)
	localparam int DayRecipW   = 26;
	localparam int DayRecipSh  = 35;
	localparam int HourShift   = 4;         // 3600 = 225 << 4
	localparam int HourOdd     = 225;
	localparam int HourRecip   = 9321;      // ceil(2^21 / 225)
	localparam int HourRecipW  = 14;
	localparam int HourRecipSh = 21;
	localparam int MinShift    = 2;         // 60 = 15 << 2
	localparam int MinOdd      = 15;
	localparam int MinRecip    = 1093;      // ceil(2^14 / 15)
	localparam int MinRecipW   = 11;
	localparam int MinRecipSh  = 14;

	localparam int InW    = 32;
	localparam int RemW   = $clog2(SecsPerDay);
	localparam int HrRemW = $clog2(SecsPerHour);
	localparam int DaysW  = 16;
	localparam int YearW  = 12;
	localparam int MonW   = 4;
	localparam int DayW   = 5;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int SecW   = 6;
	localparam int OutW   = 40;

	localparam int QDepth = 2;
	localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [DaysW-1:0] days;
		logic [HourW-1:0] hour;
		logic [MinW-1:0]  minute;
		logic [SecW-1:0]  second;
	} split_t;

	function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
		logic [DayW-1:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DayW'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    d = DayW'(30);
			4'd2:                                       d = leap ? DayW'(29) : DayW'(28);
			default:                                    d = DayW'(31);
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- sv/e2cal_queue.sv -----
// Short queue between the front (time-of-day split) and back (calendar walk).
// Register FIFO of split_t records; uses e2cal_pkg.
`default_nettype none

module e2cal_queue
	import e2cal_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire split_t push_data,
	output logic        full,
	input  wire logic   pop,
	output split_t      pop_data,
	output logic        empty
);

	split_t             mem_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCntW-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == QCntW'(QDepth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/e2cal_front.sv -----
// Front end: accepts a seconds count and splits it into days, hour, minute, second.
// Constant divides by reciprocal multiply, quotient and remainder on separate cycles; uses e2cal_pkg.
`default_nettype none

module e2cal_front
	import e2cal_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [InW-1:0]   in_secs,
	output logic                  q_push,
	output split_t                q_data,
	input  wire logic             q_full
);

	typedef enum logic [7:0] {
		F_IDLE = 8'b0000_0001,
		F_DAY  = 8'b0000_0010,
		F_DREM = 8'b0000_0100,
		F_HOUR = 8'b0000_1000,
		F_HREM = 8'b0001_0000,
		F_MIN  = 8'b0010_0000,
		F_MREM = 8'b0100_0000,
		F_PUSH = 8'b1000_0000
	} fstate_t;

	localparam int DayXW  = InW - DayShift;
	localparam int DayPW  = DayXW + DayRecipW;
	localparam int HourXW = RemW - HourShift;
	localparam int HourPW = HourXW + HourRecipW;
	localparam int MinXW  = HrRemW - MinShift;
	localparam int MinPW  = MinXW + MinRecipW;

	fstate_t           state_q;
	logic [InW-1:0]    secs_q;
	logic [DaysW-1:0]  days_q;
	logic [RemW-1:0]   sod_q;
	logic [HourW-1:0]  hour_q;
	logic [HrRemW-1:0] soh_q;
	logic [MinW-1:0]   minute_q;
	logic [SecW-1:0]   second_q;

	logic [DayXW-1:0]  day_x;
	logic [DayPW-1:0]  day_prod;
	logic [DayXW-1:0]  day_odd;
	logic [HourXW-1:0] hour_x;
	logic [HourPW-1:0] hour_prod;
	logic [HourXW-1:0] hour_odd;
	logic [MinXW-1:0]  min_x;
	logic [MinPW-1:0]  min_prod;
	logic [MinXW-1:0]  min_odd;

	// days, then seconds of day, then hour, seconds of hour, minute, second
	assign day_x     = secs_q[InW-1:DayShift];
	assign day_prod  = DayPW'(day_x) * DayPW'(DayRecip);
	assign day_odd   = day_x - DayXW'(days_q) * DayXW'(DayOdd);
	assign hour_x    = sod_q[RemW-1:HourShift];
	assign hour_prod = HourPW'(hour_x) * HourPW'(HourRecip);
	assign hour_odd  = hour_x - HourXW'(hour_q) * HourXW'(HourOdd);
	assign min_x     = soh_q[HrRemW-1:MinShift];
	assign min_prod  = MinPW'(min_x) * MinPW'(MinRecip);
	assign min_odd   = min_x - MinXW'(minute_q) * MinXW'(MinOdd);

	assign in_ready = (state_q == F_IDLE);
	assign q_push   = (state_q == F_PUSH);
	assign q_data   = '{days: days_q, hour: hour_q, minute: minute_q, second: second_q};

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				secs_q <= in_secs;
			end
			F_DAY: begin
				days_q <= day_prod[DayRecipSh +: DaysW];
			end
			F_DREM: begin
				sod_q <= {day_odd[RemW-DayShift-1:0], secs_q[DayShift-1:0]};
			end
			F_HOUR: begin
				hour_q <= hour_prod[HourRecipSh +: HourW];
			end
			F_HREM: begin
				soh_q <= {hour_odd[HrRemW-HourShift-1:0], sod_q[HourShift-1:0]};
			end
			F_MIN: begin
				minute_q <= min_prod[MinRecipSh +: MinW];
			end
			F_MREM: begin
				second_q <= {min_odd[SecW-MinShift-1:0], soh_q[MinShift-1:0]};
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_DAY;
					end
				end
				F_DAY:  state_q <= F_DREM;
				F_DREM: state_q <= F_HOUR;
				F_HOUR: state_q <= F_HREM;
				F_HREM: state_q <= F_MIN;
				F_MIN:  state_q <= F_MREM;
				F_MREM: state_q <= F_PUSH;
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/e2cal_back.sv -----
// Back end: walks whole years then whole months off the day count, holds the result beat.
// Leap rule kept by mod-100 and mod-400 year counters; uses e2cal_pkg.
`default_nettype none

module e2cal_back
	import e2cal_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire split_t           q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OutW-1:0]       out_data
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_YEAR = 4'b0010,
		B_MON  = 4'b0100,
		B_DONE = 4'b1000
	} bstate_t;

	localparam int C100W = $clog2(CentYears);
	localparam int C400W = $clog2(QuadCent);

	bstate_t           state_q;
	logic [DaysW-1:0]  days_q;
	logic [YearW-1:0]  year_q;
	logic [MonW-1:0]   month_q;
	logic [C100W-1:0]  c100_q;
	logic [C400W-1:0]  c400_q;
	logic [HourW-1:0]  hour_q;
	logic [MinW-1:0]   minute_q;
	logic [SecW-1:0]   second_q;
	logic              out_valid_q;
	logic [OutW-1:0]   out_data_q;

	logic              leap;
	logic [8:0]        ylen;
	logic [DayW-1:0]   mlen;
	logic              out_free;
	logic              load_out;
	logic [DayW-1:0]   day_out;

	assign leap = ((year_q[1:0] == 2'b00) && (c100_q != '0)) || (c400_q == '0);
	assign ylen = leap ? 9'(YearLenLeap) : 9'(YearLenStd);
	assign mlen = month_len(month_q, leap);

	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == B_DONE) && out_free;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign day_out  = days_q[DayW-1:0] + 1'b1;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				days_q   <= q_data.days;
				hour_q   <= q_data.hour;
				minute_q <= q_data.minute;
				second_q <= q_data.second;
				year_q   <= YearW'(BaseYear);
				c100_q   <= '0;
				c400_q   <= '0;
				month_q  <= MonW'(1);
			end
			B_YEAR: begin
				if (days_q >= DaysW'(ylen)) begin
					days_q <= days_q - DaysW'(ylen);
					year_q <= year_q + 1'b1;
					c100_q <= (c100_q == C100W'(CentYears - 1)) ? '0 : c100_q + 1'b1;
					c400_q <= (c400_q == C400W'(QuadCent - 1)) ? '0 : c400_q + 1'b1;
				end
			end
			B_MON: begin
				if ((month_q != MonW'(MonthsPerYr)) && (days_q >= DaysW'(mlen))) begin
					days_q  <= days_q - DaysW'(mlen);
					month_q <= month_q + 1'b1;
				end
			end
			B_DONE: begin
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_data_q <= {2'b00, second_q, minute_q, hour_q, day_out, month_q, year_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_YEAR;
					end
				end
				B_YEAR: begin
					if (days_q < DaysW'(ylen)) begin
						state_q <= B_MON;
					end
				end
				B_MON: begin
					if ((month_q == MonW'(MonthsPerYr)) || (days_q < DaysW'(mlen))) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MON) |-> (month_q >= MonW'(1)) && (month_q <= MonW'(MonthsPerYr)))
		else $error("month out of range during walk");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_YEAR) |-> (year_q <= YearW'(MaxYear)))
		else $error("year walk overran");

	a_leap_ctrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_YEAR) |-> (c100_q < C100W'(CentYears)) && (c400_q < C400W'(QuadCent)))
		else $error("leap counters out of range");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE) |-> (days_q < DaysW'(mlen)))
		else $error("day of month beyond month length");

endmodule

`default_nettype wire

// ----- sv/epoch_seconds_to_calendar_unit.sv -----
// Epoch-seconds to calendar converter, top level.
// Instantiates e2cal_front, e2cal_queue and e2cal_back; uses e2cal_pkg.
//
// Input channel s_*: one beat carries a 32-bit count of seconds since 2000-01-01 00:00:00.
// Output channel m_*: one beat per input with year, month, day, hour, minute, second.
// Front: reciprocal multiplies split off days (/86400), hour (/3600) and minute and
// second (/60), quotient and remainder on separate cycles; the push waits on a full queue.
// A two-entry queue hands the split to the back, which subtracts one year per cycle
// (up to 136) and one month per cycle (up to 11), then holds the result until
// the output register is free. Front and back overlap through the queue.
// s_tready is high only while the front is idle.
// A stalled m_tready holds the result in the output register; the back then waits and the
// queue and front fill up before s_tready stays low.
// Reset empties the queue and returns both sides to idle; no result is pending after it.
`default_nettype none

module epoch_seconds_to_calendar_unit
	import e2cal_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [InW-1:0]   s_tdata,   // [31:0] elapsed_seconds
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OutW-1:0]       m_tdata    // [11:0] year, [15:12] month, [20:16] day,
	                                         // [25:21] hour, [31:26] minute, [37:32] second
);

	logic    q_push;
	logic    q_full;
	logic    q_pop;
	logic    q_empty;
	split_t  q_wdata;
	split_t  q_rdata;

	e2cal_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_secs  (s_tdata),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	e2cal_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	e2cal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- dv/tb_epoch_seconds_to_calendar_unit.sv -----
// Self-checking testbench for epoch_seconds_to_calendar_unit: epoch seconds in, calendar date out.
// Directed date edges, then random counts under three idling phases, each beat checked field by field.
// Depends on e2cal_pkg and the RTL under sv/.

module tb_epoch_seconds_to_calendar_unit
	import e2cal_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 2000;
	localparam int PhaseItems  = 700;
	localparam int StallLimit  = 4000;
	localparam int DrainCycles = 250;
	localparam int ReportMax   = 10;

	// m_tdata layout, lowest bits last
	typedef struct packed {
		logic [OutW-38-1:0] pad;
		logic [SecW-1:0]    second;
		logic [MinW-1:0]    minute;
		logic [HourW-1:0]   hour;
		logic [DayW-1:0]    day;
		logic [MonW-1:0]    month;
		logic [YearW-1:0]   year;
	} cal_date_t;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [InW-1:0]  s_tdata  = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;

	logic            in_taken = 1'b0;
	logic [InW-1:0]  secs_pending[$];
	cal_date_t       dates_due[$];
	int              issued       = 0;
	int              checked      = 0;
	int              bad_beats    = 0;
	int              stall_cycles = 0;
	int              leap_days    = 0;
	int              year_lo      = MaxYear;
	int              year_hi      = 0;

	epoch_seconds_to_calendar_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2ns clk = ~clk;

	function automatic bit leap_year(input int unsigned yr);
		return ((yr % 4 == 0) && (yr % CentYears != 0)) || (yr % QuadCent == 0);
	endfunction

	function automatic int unsigned month_day_count(input int unsigned yr, input int unsigned mon);
		case (mon)
			4, 6, 9, 11: return 30;
			MonthFeb:    return leap_year(yr) ? 29 : 28;
			default:     return 31;
		endcase
	endfunction

	function automatic int unsigned year_start_day(input int unsigned yr);
		int unsigned d;
		d = 0;
		for (int unsigned y = BaseYear; y < yr; y++) begin
			d += leap_year(y) ? YearLenLeap : YearLenStd;
		end
		return d;
	endfunction

	function automatic cal_date_t calendar_of(input logic [InW-1:0] secs);
		cal_date_t   r;
		int unsigned days, sod, yr, mon, span;
		days = secs / SecsPerDay;
		sod  = secs % SecsPerDay;
		yr   = BaseYear;
		span = leap_year(yr) ? YearLenLeap : YearLenStd;
		while (days >= span) begin
			days -= span;
			yr++;
			span = leap_year(yr) ? YearLenLeap : YearLenStd;
		end
		for (mon = 1; mon < MonthsPerYr; mon++) begin
			span = month_day_count(yr, mon);
			if (days < span)
				break;
			days -= span;
		end
		r.pad    = '0;
		r.year   = YearW'(yr);
		r.month  = MonW'(mon);
		r.day    = DayW'(days + 1);
		r.hour   = HourW'(sod / SecsPerHour);
		r.minute = MinW'((sod % SecsPerHour) / SecsPerMin);
		r.second = SecW'(sod % SecsPerMin);
		return r;
	endfunction

	function automatic logic [InW-1:0] random_secs();
		longint unsigned d;
		case ($urandom_range(0, 3))
			0, 1: return $urandom();
			2: begin
				// land near year ends, leap days and month turns
				d = year_start_day($urandom_range(BaseYear, MaxYear - 1));
				case ($urandom_range(0, 5))
					0: d += 0;
					1: d += 58;
					2: d += 59;
					3: d += 60;
					4: d += 364;
					default: d += 365;
				endcase
				return InW'(d * SecsPerDay + ($urandom_range(0, 1) ? 0 : SecsPerDay - 1));
			end
			default: return $urandom() >> $urandom_range(0, 31);
		endcase
	endfunction

	// sender and receiver, both move on the falling edge
	always @(negedge clk) begin
		int s_idle, r_idle;
		if (issued < PhaseItems) begin
			s_idle = 17;
			r_idle = 51;
		end else if (issued < 2 * PhaseItems) begin
			s_idle = 51;
			r_idle = 17;
		end else begin
			s_idle = 0;
			r_idle = 0;
		end
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (secs_pending.size() > 0 && $urandom_range(0, 99) >= s_idle) begin
					s_tvalid <= 1'b1;
					s_tdata  <= secs_pending.pop_front();
					issued++;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= r_idle);
		end
	end

	// monitor: results are checked before the new input beat is predicted
	always @(posedge clk) begin
		cal_date_t got, want;
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (dates_due.size() == 0) begin
					if (bad_beats < ReportMax)
						$display("result beat %0d with no conversion outstanding: %h",
							checked, m_tdata);
					bad_beats++;
				end else begin
					want = dates_due.pop_front();
					if (got.pad != want.pad || got.year != want.year ||
							got.month != want.month || got.day != want.day ||
							got.hour != want.hour || got.minute != want.minute ||
							got.second != want.second) begin
						if (bad_beats < ReportMax)
							$display({"beat %0d: expected %0d-%0d-%0d %0d:%0d:%0d pad %0h,",
								" got %0d-%0d-%0d %0d:%0d:%0d pad %0h"}, checked,
								want.year, want.month, want.day, want.hour, want.minute,
								want.second, want.pad, got.year, got.month, got.day,
								got.hour, got.minute, got.second, got.pad);
						bad_beats++;
					end
					if (got.month == MonthFeb && got.day == 29)
						leap_days++;
					if (got.year < year_lo)
						year_lo = got.year;
					if (got.year > year_hi)
						year_hi = got.year;
				end
				checked++;
			end
			if (s_tvalid && s_tready)
				dates_due.push_back(calendar_of(s_tdata));
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles == StallLimit) begin
				$display("watchdog: no beat for %0d cycles, %0d conversions outstanding",
					StallLimit, dates_due.size());
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		// epoch start, minute/hour/day edges, leap day in 2000 and 2004,
		// non-leap February in 2001 and 2100, year turn, top of the range
		secs_pending = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
			32'd86400, 32'd5097599, 32'd5097600, 32'd5183999, 32'd5184000, 32'd31622399,
			32'd31622400, 32'd36720000, 32'd131328000, 32'd3160857599, 32'd3160857600,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE,
			32'hFFFF_FFFF};
		repeat (RandomItems)
			secs_pending.push_back(random_secs());

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (secs_pending.size() != 0 || s_tvalid || dates_due.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("%0d conversions checked, years %0d to %0d, %0d falling on 29 February",
			checked, year_lo, year_hi, leap_days);
		$display("stimulus: date edges and full 32-bit range, then random counts with idling");
		if (bad_beats == 0 && dates_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
